/* design/dcc_pkg.sv */
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants of the distinct color collector
// Holds the field widths and the probe record that walks down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package dcc_pkg;

   // field widths
   localparam int COLOR_W     = 24;
   localparam int IDX_W       = 8;
   localparam int COUNT_W     = 9;
   localparam int TABLE_DEPTH = 256;

   // one pixel on its way down the chain, with its lookup outcome so far
   typedef struct packed {
      logic               active;
      logic [COLOR_W-1:0] color;
      logic               last;
      logic               resolved;
      logic               is_new;
      logic [IDX_W-1:0]   idx;
   } probe_type;

endpackage

`default_nettype wire

/* design/dcc_cell.sv */
// ----------------------------------------------------------------------------
// dcc_cell: one table entry of the distinct color collector
// Holds one stored color, compares the passing probe against it, stores the
// probe color when it is the first free entry, and hands the probe on.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_cell #(
   parameter int CELL_INDEX = 0,
   parameter int CNT_W      = 9
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic [CNT_W-1:0]          count,
   input  wire dcc_pkg::probe_type        upstream_probe,
   output dcc_pkg::probe_type             downstream_probe
);

   localparam logic [dcc_pkg::IDX_W-1:0] CELL_IDX   = dcc_pkg::IDX_W'(CELL_INDEX);
   localparam logic [CNT_W-1:0]          CELL_COUNT = CNT_W'(CELL_INDEX);

   dcc_pkg::probe_type probe_ff, probe_in;
   logic [dcc_pkg::COLOR_W-1:0] entry_ff, entry_in;
   logic occupied;
   logic store;

   // probe stage moves only while the chain advances
   always_comb begin
      probe_in = advance ? upstream_probe : probe_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   // entries below the running count hold valid colors
   assign occupied = (CELL_COUNT < count);
   assign store    = probe_ff.active && !probe_ff.resolved && !occupied;

   // first free entry takes the new color
   always_comb begin
      entry_in = store ? probe_ff.color : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // resolve the probe on a match or on the first free entry
   always_comb begin
      downstream_probe = probe_ff;
      if (probe_ff.active && !probe_ff.resolved) begin
         if (occupied && (entry_ff == probe_ff.color)) begin
            downstream_probe.resolved = 1'b1;
            downstream_probe.idx      = CELL_IDX;
         end else if (!occupied) begin
            downstream_probe.resolved = 1'b1;
            downstream_probe.is_new   = 1'b1;
            downstream_probe.idx      = CELL_IDX;
         end
      end
   end

endmodule

`default_nettype wire

/* design/distinct_color_collector_unit.sv */
// ----------------------------------------------------------------------------
// distinct_color_collector_unit: table of distinct colors of an image
// Looks up each pixel color in a chain of entry cells, appends new colors and
// reports index, novelty, running count and overflow for every pixel.
// ----------------------------------------------------------------------------
// One pixel is looked up at a time. An accepted pixel walks down a chain of
// min(MAX_COLORS, 256) cells, one cell per cycle unless the chain holds, and
// its result beat is registered as it leaves the last cell; a new pixel is
// taken the cycle after that, so no new pixel enters before the last one has
// left the chain. A finished result may wait at the output while the next
// pixel already walks the chain; the chain holds only when a pixel reaches
// its end while the output beat is still not taken. A pixel with tlast set
// empties the table once its result is formed.
`default_nettype none

module distinct_color_collector_unit #(
   parameter int MAX_COLORS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: pixel_red, pixel_green, pixel_blue (lowest bits first)
   input  wire logic [23:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: color_index, is_new, distinct_count, table_overflow, zero pad
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);

   localparam int CAP   = (MAX_COLORS < dcc_pkg::TABLE_DEPTH) ?
                          MAX_COLORS : dcc_pkg::TABLE_DEPTH;
   localparam int CNT_W = $clog2(CAP + 1);
   localparam int OUT_CNT_W = dcc_pkg::COUNT_W;
   localparam int IDX_W     = dcc_pkg::IDX_W;

   dcc_pkg::probe_type chain [0:CAP];
   dcc_pkg::probe_type entry_probe;
   dcc_pkg::probe_type exit_probe;

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     count_after;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic [OUT_CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 req_accept;
   logic                 advance;
   logic                 exit_load;

   // input beat handshake
   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;

   // probe entering the first cell
   always_comb begin
      entry_probe        = '0;
      entry_probe.active = req_accept;
      entry_probe.color  = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      entry_probe.last   = req_tlast;
   end

   assign chain[0] = entry_probe;

   // chain holds only when the leaving probe finds the output beat still full
   assign exit_probe = chain[CAP];
   assign advance    = !(exit_probe.active && rsp_valid_ff && !rsp_tready);
   assign exit_load  = exit_probe.active && advance;

   // cell chain
   for (genvar k = 0; k < CAP; k++) begin : g_cell
      dcc_cell #(
         .CELL_INDEX(k),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .advance         (advance),
         .count           (count_ff),
         .upstream_probe  (chain[k]),
         .downstream_probe(chain[k+1])
      );
   end

   // running count, cleared after the last pixel of an image
   assign count_after = count_ff + CNT_W'(exit_probe.is_new);

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end
      if (exit_load) begin
         busy_in  = 1'b0;
         count_in = exit_probe.last ? '0 : count_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // output beat register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      if (exit_load) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = exit_probe.resolved ? exit_probe.idx : '0;
         rsp_new_in   = exit_probe.is_new;
         rsp_count_in = OUT_CNT_W'(count_after);
         rsp_ovf_in   = !exit_probe.resolved;
         rsp_last_in  = exit_probe.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_idx_ff   <= rsp_idx_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_ovf_ff, rsp_count_ff, rsp_new_ff, rsp_idx_ff};

   // a probe leaves the chain only while a pixel is in flight
   assert property (@(posedge clock) disable iff (reset)
      exit_probe.active |-> busy_ff)
      else $error("probe left the chain with no pixel in flight");

   // the count never passes the table capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAP))
      else $error("distinct count above table capacity");

   // the count moves only when a pixel finishes
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |=> $stable(count_ff))
      else $error("distinct count changed with no pixel in flight");

   // a new entry and an overflow never come together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_new_ff && rsp_ovf_ff))
      else $error("result both new and overflowed");

endmodule

`default_nettype wire

/* test/color_table_checker.sv */
// ----------------------------------------------------------------------------
// color_table_checker: lookup predictor and result checker
// Watches the pixel and result streams of the distinct color collector, keeps
// its own table of colors seen in the current image, and compares every result
// beat field by field with the oldest predicted lookup.
// ----------------------------------------------------------------------------
module color_table_checker #(
   parameter int MAX_COLORS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: pixel_red, pixel_green, pixel_blue (lowest bits first)
   input  wire logic [23:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // rsp_tdata: color_index, is_new, distinct_count, table_overflow, zero pad
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output int               fail_count,
   output int               pending
);

   localparam int CAPACITY = (MAX_COLORS < dcc_pkg::TABLE_DEPTH) ?
                             MAX_COLORS : dcc_pkg::TABLE_DEPTH;

   typedef struct packed {
      logic [dcc_pkg::IDX_W-1:0]   color_index;
      logic                        is_new;
      logic [dcc_pkg::COUNT_W-1:0] distinct_count;
      logic                        table_overflow;
      logic                        image_done;
   } lookup_type;

   // colors stored so far in the current image
   logic [dcc_pkg::COLOR_W-1:0] image_colors [dcc_pkg::TABLE_DEPTH];
   int unsigned                 image_color_count;
   lookup_type                  lookup_q [$];

   // look a color up, append it if new and there is room
   function automatic lookup_type lookup_color(input logic [dcc_pkg::COLOR_W-1:0] color,
                                               input logic last);
      lookup_type  res;
      int unsigned n;
      bit          hit;
      res = '0;
      hit = 1'b0;
      n   = image_color_count;
      if (n > CAPACITY) n = CAPACITY;
      for (int k = 0; k < n; k++) begin
         if (!hit && image_colors[k] == color) begin
            res.color_index = dcc_pkg::IDX_W'(k);
            hit = 1'b1;
         end
      end
      if (!hit) begin
         if (n < CAPACITY) begin
            image_colors[n] = color;
            res.color_index = dcc_pkg::IDX_W'(n);
            res.is_new = 1'b1;
            n++;
         end else begin
            // full table: index 0, count unchanged
            res.table_overflow = 1'b1;
         end
      end
      res.distinct_count = dcc_pkg::COUNT_W'(n);
      res.image_done = last;
      // last pixel empties the table after its result
      image_color_count = last ? 0 : n;
      return res;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endtask

   // sample both streams on the clock edge
   always @(posedge clock) begin
      lookup_type want;
      if (reset) begin
         lookup_q.delete();
         image_color_count = 0;
      end else begin
         if (req_tvalid && req_tready)
            lookup_q.push_back(lookup_color({req_tdata[7:0], req_tdata[15:8],
                                             req_tdata[23:16]}, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            if (lookup_q.size() == 0) begin
               $error("result beat with no pixel pending: tdata %h", rsp_tdata);
               fail_count++;
            end else begin
               want = lookup_q.pop_front();
               check_field("color_index", 16'(want.color_index), 16'(rsp_tdata[7:0]));
               check_field("is_new", 16'(want.is_new), 16'(rsp_tdata[8]));
               check_field("distinct_count", 16'(want.distinct_count),
                           16'(rsp_tdata[17:9]));
               check_field("table_overflow", 16'(want.table_overflow),
                           16'(rsp_tdata[18]));
               check_field("tdata pad", 16'd0, 16'(rsp_tdata[23:19]));
               check_field("image_done", 16'(want.image_done), 16'(rsp_tlast));
            end
         end
      end
      pending = lookup_q.size();
   end

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top of the distinct color collector
// Drives pixel images into the block, from hand-picked corner pixels to random
// palettes and images that fill the table past capacity, with random idling on
// both streams, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_COLORS   = 256;
   localparam int NUM_PIXELS   = 1250;
   localparam int PIXEL_CYCLES = 257;   // one walk down the cell chain
   localparam int HOLD_START   = 4000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int QUIET_TAIL   = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   int          fail_count;
   int          pending;
   bit          quiet = 1'b0;
   int          pixels_sent = 0;
   int          gap_pct = 0;

   always #10 clock = ~clock;

   distinct_color_collector_unit #(.MAX_COLORS(MAX_COLORS)) dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
   );

   color_table_checker #(.MAX_COLORS(MAX_COLORS)) u_checker (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .fail_count(fail_count), .pending(pending)
   );

   // one pixel beat, color given as {red, green, blue}
   task automatic send_pixel(input logic [23:0] color, input logic last);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tdata  <= {color[7:0], color[15:8], color[23:16]};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      if (pixels_sent >= NUM_PIXELS - QUIET_TAIL) quiet = 1'b1;
   endtask

   // image with more distinct colors than the table holds
   task automatic fill_image(input int extra, input bit end_on_hit);
      logic [23:0] stored [256];
      logic [23:0] color;
      logic [7:0]  salt;
      int          len;
      salt = 8'($urandom);
      len  = 256 + extra;
      for (int k = 0; k < len; k++) begin
         if (k < 256) begin
            color = {8'(k) ^ salt, 16'($urandom)};
            stored[k] = color;
         end else if (k == len - 1) begin
            color = end_on_hit ? stored[$urandom_range(0, 255)] : 24'($urandom);
         end else begin
            // hits in a full table mixed with overflowing colors
            color = $urandom_range(0, 1) ? stored[$urandom_range(0, 255)]
                                         : 24'($urandom);
         end
         send_pixel(color, k == len - 1);
      end
   endtask

   // short image drawn mostly from a small palette
   task automatic palette_image();
      logic [23:0] palette [24];
      logic [23:0] color;
      int          n_colors;
      int          len;
      n_colors = $urandom_range(1, 24);
      len      = $urandom_range(1, 40);
      for (int k = 0; k < n_colors; k++) begin
         if ($urandom_range(0, 7) == 0)
            palette[k] = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         else
            palette[k] = 24'($urandom);
      end
      for (int k = 0; k < len; k++) begin
         color = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                             : palette[$urandom_range(0, n_colors - 1)];
         send_pixel(color, k == len - 1);
      end
   endtask

   // result side: random stalls, one long hold-off
   initial begin : result_side
      int cycle_n;
      int idle_pct;
      bit held_off;
      cycle_n  = 0;
      idle_pct = 0;
      held_off = 1'b0;
      wait (!reset);
      forever begin
         if (cycle_n % 1000 == 0)
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
         if (!held_off && cycle_n >= HOLD_START) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         cycle_n++;
      end
   end

   // pixel side and verdict
   initial begin : pixel_side
      logic [23:0] corner_colors [16];
      bit          corner_last [16];
      int          image_n;
      int          drain_n;
      corner_colors = '{
         24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
         24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h0000FF,
         24'hFFFFFF, 24'hFFFFFF, 24'h123456, 24'h123456,
         24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555
      };
      corner_last = '{0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 1, 0, 0, 0, 1};
      image_n = 0;
      drain_n = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // extremes, hits, new last pixels, single pixel images
      gap_pct = 20;
      for (int k = 0; k < 16; k++) send_pixel(corner_colors[k], corner_last[k]);

      // sender pause until the block is empty
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // random images, two of them overfilling the table
      while (pixels_sent < NUM_PIXELS) begin
         gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
         if (image_n == 0)
            fill_image($urandom_range(20, 50), 1'b0);
         else if (image_n == 12)
            fill_image($urandom_range(10, 30), 1'b1);
         else
            palette_image();
         if (image_n == 6) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         image_n++;
      end
      req_tvalid <= 1'b0;

      // drain, then allow one more chain walk for stray beats
      while (pending != 0 && drain_n < 20 * PIXEL_CYCLES) begin
         @(posedge clock);
         drain_n++;
      end
      repeat (PIXEL_CYCLES + 20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
